### hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

  // sample and count widths
  localparam int unsigned SampleW   = 24;
  localparam int unsigned CountW    = 7;
  localparam int unsigned WindowMax = 64;
  localparam int unsigned AddrW     = $clog2(WindowMax);

  // accumulator widths: sum, sum of squares, n*q - s*s
  localparam int unsigned SumW   = 30;
  localparam int unsigned SqSumW = 54;
  localparam int unsigned DevW   = 61;

  // divisor holds n*n, variance and root widths
  localparam int unsigned DivisorW = 13;
  localparam int unsigned VarW     = 48;
  localparam int unsigned RootW    = 24;

  // register port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = ApbAddrW - 2;

  localparam logic [RegIdxW-1:0] RegWindowWidth = '0;
  localparam logic [CountW-1:0]  WidthReset     = CountW'(WindowMax);

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

### hw/rtl/swm_div.sv
`timescale 1ns / 1ps

module swm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [swm_pkg::DevW-1:0]      dividend_i,
  input  logic [swm_pkg::DivisorW-1:0]  divisor_i,
  output logic [swm_pkg::DevW-1:0]      quot_o,
  output swm_pkg::unit_st_t             st_o
);
  import swm_pkg::*;

  localparam int unsigned CntW = $clog2(DevW);

  logic [DevW-1:0]     dq_q;
  logic [DivisorW-1:0] dvs_q;
  logic [DivisorW-1:0] rem_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [DivisorW:0]   rem_sh;
  logic [DivisorW:0]   rem_diff;
  logic                take;

  // one quotient bit per cycle, restoring
  assign rem_sh   = {rem_q, dq_q[DevW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign take     = (rem_sh >= {1'b0, dvs_q});

  // dividend shifts out on top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DevW-2:0], take};
      rem_q <= take ? rem_diff[DivisorW-1:0] : rem_sh[DivisorW-1:0];
    end
  end

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DevW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o = dq_q;
  assign st_o   = '{busy: busy_q, done: done_q};

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a run");

endmodule

### hw/rtl/swm_sqrt.sv
`timescale 1ns / 1ps

module swm_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swm_pkg::VarW-1:0]   radicand_i,
  output logic [swm_pkg::RootW-1:0]  root_o,
  output swm_pkg::unit_st_t          st_o
);
  import swm_pkg::*;

  localparam int unsigned CntW = $clog2(RootW);
  localparam int unsigned RemW = RootW + 2;

  logic [VarW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic [RemW+1:0]  rem_diff;
  logic             take;

  // one root bit per cycle: bring down two radicand bits, try 4*root+1
  assign rem_sh   = {rem_q, rad_q[VarW-1 -: 2]};
  assign trial    = (RemW+2)'({root_q, 2'b01});
  assign rem_diff = rem_sh - trial;
  assign take     = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[VarW-3:0], 2'b00};
      rem_q  <= take ? rem_diff[RemW-1:0] : rem_sh[RemW-1:0];
      root_q <= {root_q[RootW-2:0], take};
    end
  end

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = root_q;
  assign st_o   = '{busy: busy_q, done: done_q};

  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q <= {root_q, 1'b0}))
    else $error("root remainder above twice the partial root");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("root unit started while busy");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("root unit done without a run");

endmodule

### hw/rtl/sliding_window_mean_stddev.sv
// Sliding-window mean and standard deviation of 24-bit elapsed-time samples.
// Each request carries one sample; it is written into a 64-entry ring and one
// result follows with the number of samples held n, the truncated mean
// floor(S/n) and the floor square root of floor((n*Q - S*S) / (n*n)), where S
// and Q are the sum and sum of squares of the n newest samples. The window
// width register (address 0, reset 64) selects how many samples are kept; 0
// acts as 1 and values above 64 act as 64, and shrinking it drops the oldest
// samples for good. The block takes one request at a time: the ring is swept
// one entry per cycle through a registered squarer, n*Q - S*S is formed by
// serial shift-add, one bit-serial divider runs twice (mean, then variance),
// then the bit-serial square root runs and the result is loaded. A finished
// result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module sliding_window_mean_stddev (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swm_pkg::ApbAddrW-1:0]   paddr,
  input  logic [swm_pkg::ApbDataW-1:0]   pwdata,
  output logic [swm_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [swm_pkg::SampleW-1:0]    elapsed_us_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [swm_pkg::CountW-1:0]     sample_count_o,
  output logic [swm_pkg::SampleW-1:0]    mean_us_o,
  output logic [swm_pkg::SampleW-1:0]    stddev_us_o
);
  import swm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SWEEP = 8'b0000_0010,
    ST_MULQ  = 8'b0000_0100,
    ST_MULS  = 8'b0000_1000,
    ST_DIVM  = 8'b0001_0000,
    ST_DIVV  = 8'b0010_0000,
    ST_ROOT  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration and window bookkeeping
  logic [CountW-1:0]    width_q;
  logic [CountW-1:0]    eff_w;
  logic [CountW-1:0]    fill_q;
  logic [CountW-1:0]    fill_clamp;
  logic [CountW-1:0]    fill_new;
  logic [AddrW-1:0]     wp_q;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 reg_wr;

  // ring and sweep pipeline
  logic [SampleW-1:0]   mem_q [WindowMax];
  logic [SampleW-1:0]   rd_data_q;
  logic [AddrW-1:0]     rd_addr_q;
  logic [CountW-1:0]    rd_left_q;
  logic                 rd_en;
  logic                 rd_vld_q;
  logic                 sq_vld_q;
  logic [SampleW-1:0]   smp_q;
  logic [2*SampleW-1:0] sq_prod;
  logic [2*SampleW-1:0] sq_q;
  logic [SumW-1:0]      sum_q;
  logic [SqSumW-1:0]    qsum_q;
  logic                 sweep_done;

  // serial multiply-accumulate for n*q - s*s
  logic [DevW-1:0]      mcand_q;
  logic [SumW-1:0]      mplier_q;
  logic [DevW-1:0]      acc_q;

  // shared divider and root
  logic                 div_start;
  logic [DevW-1:0]      div_dividend;
  logic [DivisorW-1:0]  div_divisor;
  logic [DevW-1:0]      div_quot;
  unit_st_t             div_st;
  logic [2*CountW-1:0]  nsq_full;
  logic                 sqrt_start;
  logic [RootW-1:0]     root;
  unit_st_t             sqrt_st;
  logic [SampleW-1:0]   mean_q;

  // result register
  logic                 accept;
  logic                 out_load;
  logic                 out_vld_q;
  logic [CountW-1:0]    out_count_q;
  logic [SampleW-1:0]   out_mean_q;
  logic [SampleW-1:0]   out_sd_q;

  // register port
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign reg_wr  = psel && penable && pwrite && (reg_idx == RegWindowWidth);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == RegWindowWidth) ? ApbDataW'(width_q) : '0;

  // effective width and the count after this request
  always_comb begin
    if (width_q == '0) begin
      eff_w = CountW'(1);
    end else if (width_q > CountW'(WindowMax)) begin
      eff_w = CountW'(WindowMax);
    end else begin
      eff_w = width_q;
    end
    fill_clamp = (fill_q > eff_w) ? eff_w : fill_q;
    fill_new   = (fill_clamp < eff_w) ? fill_clamp + CountW'(1) : fill_clamp;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign rd_en      = (state_q == ST_SWEEP) && (rd_left_q != '0);
  assign sweep_done = (rd_left_q == '0) && !rd_vld_q && !sq_vld_q;
  assign sq_prod    = rd_data_q * rd_data_q;
  assign nsq_full   = fill_q * fill_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sweep_done) state_d = ST_MULQ;
      end
      ST_MULQ: begin
        if (mplier_q == '0) state_d = ST_MULS;
      end
      ST_MULS: begin
        if (mplier_q == '0) begin
          div_start = 1'b1;
          state_d   = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (div_st.done) begin
          div_start = 1'b1;
          state_d   = ST_DIVV;
        end
      end
      ST_DIVV: begin
        if (div_st.done) begin
          sqrt_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_st.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // divider operands: s / n first, then (n*q - s*s) / (n*n)
  assign div_dividend = (state_q == ST_DIVM) ? acc_q : DevW'(sum_q);
  assign div_divisor  = (state_q == ST_DIVM) ? nsq_full[DivisorW-1:0] : DivisorW'(fill_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      width_q   <= WidthReset;
      fill_q    <= '0;
      wp_q      <= '0;
      rd_left_q <= '0;
      rd_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      sq_vld_q <= rd_vld_q;
      if (reg_wr) width_q <= pwdata[CountW-1:0];
      if (accept) begin
        fill_q    <= fill_new;
        wp_q      <= wp_q + AddrW'(1);
        rd_left_q <= fill_new;
      end else if (rd_en) begin
        rd_left_q <= rd_left_q - CountW'(1);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // sample ring: write on request, one registered read per sweep cycle while entries remain
  always_ff @(posedge clk_i) begin
    if (accept) mem_q[wp_q] <= elapsed_us_i;
    if (rd_en) rd_data_q <= mem_q[rd_addr_q];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_addr_q <= wp_q;
    end else if (rd_en) begin
      rd_addr_q <= rd_addr_q - AddrW'(1);
    end

    if (rd_vld_q) begin
      smp_q <= rd_data_q;
      sq_q  <= sq_prod;
    end

    if (accept) begin
      sum_q  <= '0;
      qsum_q <= '0;
    end else if (sq_vld_q) begin
      sum_q  <= sum_q + SumW'(smp_q);
      qsum_q <= qsum_q + SqSumW'(sq_q);
    end

    case (state_q)
      ST_SWEEP: begin
        if (sweep_done) begin
          mcand_q  <= DevW'(qsum_q);
          mplier_q <= SumW'(fill_q);
          acc_q    <= '0;
        end
      end
      // acc = n * q
      ST_MULQ: begin
        if (mplier_q != '0) begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end else begin
          mcand_q  <= DevW'(sum_q);
          mplier_q <= sum_q;
        end
      end
      // acc = n * q - s * s
      ST_MULS: begin
        if (mplier_q != '0) begin
          if (mplier_q[0]) acc_q <= acc_q - mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
      end
      ST_DIVM: begin
        if (div_st.done) mean_q <= div_quot[SampleW-1:0];
      end
      default: ;
    endcase

    if (out_load) begin
      out_count_q <= fill_q;
      out_mean_q  <= mean_q;
      out_sd_q    <= root;
    end
  end

  swm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .st_o       (div_st)
  );

  swm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quot[VarW-1:0]),
    .root_o     (root),
    .st_o       (sqrt_st)
  );

  assign out_valid_o    = out_vld_q;
  assign sample_count_o = out_count_q;
  assign mean_us_o      = out_mean_q;
  assign stddev_us_o    = out_sd_q;

  a_mean_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVM && div_st.done) |-> (div_quot[DevW-1:SampleW] == '0))
    else $error("mean quotient wider than a sample");

  a_var_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVV && div_st.done) |-> (div_quot[DevW-1:VarW] == '0))
    else $error("variance quotient wider than the root input");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (fill_q != '0 && fill_q <= CountW'(WindowMax)))
    else $error("held count out of range after a request");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVM || state_q == ST_DIVV) |-> (div_st.busy || div_st.done))
    else $error("waiting on an idle divider");

  a_root_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (sqrt_st.busy || sqrt_st.done))
    else $error("waiting on an idle root unit");

endmodule

### tb/tb_sliding_window_mean_stddev.sv
`timescale 1ns / 1ps

module tb_sliding_window_mean_stddev;
  import swm_pkg::*;

  // register addresses on the config port
  localparam logic [ApbAddrW-1:0] AddrWindowWidth = {RegWindowWidth, 2'b00};
  localparam logic [ApbAddrW-1:0] AddrUnmapped    = {~RegWindowWidth, 2'b00};

  localparam int unsigned RandomItems = 1900;
  localparam int unsigned MaxReported = 10;
  localparam logic [SampleW-1:0] SampleMax = '1;

  // shape of the samples within one random phase
  typedef enum int {
    SAMPLE_UNIFORM,
    SAMPLE_SMALL,
    SAMPLE_NEAR_CONST,
    SAMPLE_EXTREMES,
    SAMPLE_HIGH
  } sample_mode_e;

  typedef struct packed {
    logic [CountW-1:0]  count;
    logic [SampleW-1:0] mean;
    logic [SampleW-1:0] stddev;
  } window_stats_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  elapsed_us_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CountW-1:0]   sample_count_o;
  logic [SampleW-1:0]  mean_us_o;
  logic [SampleW-1:0]  stddev_us_o;

  sliding_window_mean_stddev uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .elapsed_us_i   (elapsed_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_count_o (sample_count_o),
    .mean_us_o      (mean_us_o),
    .stddev_us_o    (stddev_us_o)
  );

  // shadow of the block state
  logic [SampleW-1:0] window_ring [WindowMax];
  logic [CountW-1:0]  width_shadow = WidthReset;
  int unsigned        held_count = 0;
  int unsigned        ring_pos = 0;

  logic [SampleW-1:0] pending_samples [$];
  window_stats_t      expected_stats [$];

  int unsigned mismatch_count = 0;
  int unsigned samples_taken = 0;
  int unsigned results_checked = 0;
  int unsigned phase_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_hold = 0;
  bit          quiet = 1'b0;

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // statistics of the newest samples after storing one more
  task automatic predict_window_stats(input logic [SampleW-1:0] x);
    int unsigned   w;
    int unsigned   k;
    logic [63:0]   v;
    logic [63:0]   s;
    logic [63:0]   q;
    logic [63:0]   n;
    logic [63:0]   var_q;
    logic [63:0]   root;
    logic [63:0]   trial;
    window_stats_t r;
    w = width_shadow;
    if (w == 0) w = 1;
    if (w > WindowMax) w = WindowMax;
    if (held_count > w) held_count = w;
    window_ring[ring_pos] = x;
    ring_pos = (ring_pos + 1) % WindowMax;
    if (held_count < w) held_count++;
    s = '0;
    q = '0;
    for (k = 0; k < held_count; k++) begin
      v = 64'(window_ring[(ring_pos + WindowMax - 1 - k) % WindowMax]);
      s += v;
      q += v * v;
    end
    n = 64'(held_count);
    // n*q and s*s both stay below 2**61
    if (n * q < s * s) var_q = '0;
    else var_q = (n * q - s * s) / (n * n);
    root = '0;
    for (k = 0; k < RootW; k++) begin
      trial = root | (64'd1 << (RootW - 1 - k));
      if (trial * trial <= var_q) root = trial;
    end
    r.count  = CountW'(held_count);
    r.mean   = SampleW'(s / n);
    r.stddev = SampleW'(root);
    expected_stats.push_back(r);
  endtask

  // idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet) return 0;
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  function automatic logic [SampleW-1:0] draw_sample(sample_mode_e mode,
                                                     logic [SampleW-1:0] base);
    case (mode)
      SAMPLE_UNIFORM:    return SampleW'($urandom);
      SAMPLE_SMALL:      return SampleW'($urandom_range(0, 1000));
      SAMPLE_NEAR_CONST: return base + SampleW'($urandom_range(0, 3));
      SAMPLE_EXTREMES:   return ($urandom_range(0, 1) == 1) ? SampleMax : '0;
      default:           return SampleMax - SampleW'($urandom_range(0, 255));
    endcase
  endfunction

  // request driver: takes samples from the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_window_stats(elapsed_us_i);
        samples_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left = gap_left - 1;
        end else if (pending_samples.size() != 0) begin
          in_valid_i <= 1'b1;
          elapsed_us_i <= pending_samples.pop_front();
          gap_left = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    window_stats_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (expected_stats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("%0t: result with none expected: count %0d mean %0d stddev %0d",
                     $time, sample_count_o, mean_us_o, stddev_us_o);
        end else begin
          exp_r = expected_stats.pop_front();
          if (sample_count_o !== exp_r.count || mean_us_o !== exp_r.mean ||
              stddev_us_o !== exp_r.stddev) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
              $display("%0t: mismatch count %0d/%0d mean %0d/%0d stddev %0d/%0d (exp/act)",
                       $time, exp_r.count, sample_count_o, exp_r.mean, mean_us_o,
                       exp_r.stddev, stddev_us_o);
          end
        end
      end
      if (stall_hold != 0) begin
        stall_hold = stall_hold - 1;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        stall_hold = $urandom_range(0, 30);
      end else begin
        stall_hold = pick_gap();
        if (stall_hold != 0) begin
          out_stall_i <= 1'b1;
          stall_hold = stall_hold - 1;
        end else begin
          stall_hold = $urandom_range(0, 10);
        end
      end
    end
  end

  // setup cycle, access cycle, then release
  task automatic reg_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrWindowWidth) width_shadow = data[CountW-1:0];
  endtask

  task automatic check_width_readback();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrWindowWidth;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (prdata !== ApbDataW'(width_shadow)) begin
      mismatch_count++;
      if (mismatch_count <= MaxReported)
        $display("%0t: width readback expected %0d got %0h", $time, width_shadow, prdata);
    end
  endtask

  // width write with junk in the unused upper bits
  task automatic set_width(input logic [CountW-1:0] w);
    logic [ApbDataW-1:0] data;
    data = $urandom;
    data[CountW-1:0] = w;
    reg_write(AddrWindowWidth, data);
    check_width_readback();
  endtask

  // wait until every request has been taken and answered
  task automatic drain();
    @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_stats.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic send(input logic [SampleW-1:0] x);
    pending_samples.push_back(x);
  endtask

  // stimulus
  initial begin
    logic [CountW-1:0]  phase_width;
    logic [SampleW-1:0] base;
    sample_mode_e       mode;
    int unsigned        len;
    int unsigned        random_sent;
    random_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset width, extremes and a mid-scale value
    check_width_readback();
    send('0);
    send(SampleMax);
    send('0);
    send(SampleMax);
    send(24'd1);
    send(24'h800000);
    drain();

    // unmapped register leaves the width alone
    reg_write(AddrUnmapped, 32'd2);
    check_width_readback();

    // shrink while six samples are held
    set_width(7'd3);
    send(24'd7);
    send(24'd7);
    send(24'd7);
    send(24'd100);
    drain();

    // zero width acts as one
    set_width(7'd0);
    send(24'hAAAAAA);
    send(24'h555555);
    drain();

    // width above the ring size saturates
    set_width(7'd127);
    send(SampleMax);
    send(SampleMax);
    send(SampleMax);
    drain();

    set_width(7'd1);
    send(24'd12345);
    drain();

    set_width(7'd2);
    send(SampleMax);
    send('0);
    send(SampleMax);
    drain();

    // random phases, each with its own width and sample shape
    while (random_sent < RandomItems) begin
      case (phase_count)
        0: phase_width = 7'd64;
        1: phase_width = 7'd1;
        2: phase_width = 7'd0;
        3: phase_width = 7'd127;
        4: phase_width = 7'd65;
        5: phase_width = 7'd2;
        6: phase_width = 7'd63;
        default: begin
          if ($urandom_range(0, 3) == 0) phase_width = CountW'($urandom);
          else phase_width = CountW'($urandom_range(1, WindowMax));
        end
      endcase
      set_width(phase_width);
      quiet = ($urandom_range(0, 4) == 0);
      mode = sample_mode_e'($urandom_range(SAMPLE_UNIFORM, SAMPLE_HIGH));
      len = $urandom_range(10, 120);
      base = SampleW'($urandom);
      repeat (len) send(draw_sample(mode, base));
      random_sent += len;
      phase_count++;
      drain();
    end

    quiet = 1'b0;
    repeat (300) @(posedge clk_i);
    $display("took %0d samples over %0d random phases, checked %0d results",
             samples_taken, phase_count, results_checked);
    $display("mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_sliding_window_mean_stddev: PASS");
    end else begin
      $display("tb_sliding_window_mean_stddev: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", expected_stats.size());
    $display("tb_sliding_window_mean_stddev: FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_div.sv
hw/rtl/swm_sqrt.sv
hw/rtl/sliding_window_mean_stddev.sv
tb/tb_sliding_window_mean_stddev.sv
